>>> hdl/gravitational_force_2d_macros.svh
// Assertion helpers shared by the checking code of the block.
`ifndef GRAVITATIONAL_FORCE_2D_MACROS_SVH
`define GRAVITATIONAL_FORCE_2D_MACROS_SVH

// Same-cycle implication, clocked on clk, off during reset
`define GF2D_ASSERT_IMPL(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off during reset
`define GF2D_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> hdl/gf2d_pkg.sv
package gf2d_pkg;

  localparam int FRAC_BITS_DEF = 16;

  localparam int POS_W  = 32;
  localparam int DIFF_W = POS_W + 1;      // exact difference of two positions
  localparam int SQ_W   = 2 * DIFF_W;     // squared length, exact
  localparam int ROOT_W = DIFF_W;         // floor sqrt of squared length
  localparam int PROD_W = ROOT_W + 32;    // clamped * len
  localparam int NUM_W  = 128;            // g * ma * mb * |d|
  localparam int Q_W    = 32;             // quotient bits below the overflow check

  // Register indexes
  localparam logic [1:0] CFG_GRAV    = 2'd0;
  localparam logic [1:0] CFG_MIN_DSQ = 2'd1;
  localparam logic [1:0] CFG_MAX_DSQ = 2'd2;

  typedef struct packed {
    logic signed [31:0] a_pos_x;
    logic signed [31:0] a_pos_y;
    logic signed [31:0] b_pos_x;
    logic signed [31:0] b_pos_y;
    logic [31:0]        a_mass;
    logic [31:0]        b_mass;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic               saturated;
    logic               degenerate;
  } out_word_t;

  typedef struct packed {
    logic neg_x;
    logic neg_y;
    logic degen;
  } gf2d_flags_t;

  typedef struct packed {
    logic [31:0]      clamped;
    logic [NUM_W-1:0] num_x;
    logic [NUM_W-1:0] num_y;
    gf2d_flags_t      flags;
  } gf2d_side_t;

endpackage

>>> hdl/gf2d_front.sv
module gf2d_front #(
  parameter int FRAC_BITS = gf2d_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  gf2d_pkg::in_word_t         in_word,
  input  logic [31:0]                grav_constant,
  input  logic [31:0]                min_dist_sq,
  input  logic [31:0]                max_dist_sq,
  output logic                       out_valid,
  output logic [gf2d_pkg::SQ_W-1:0]  d2,
  output gf2d_pkg::gf2d_side_t       side
);
  import gf2d_pkg::*;

  // stage 1: differences, g*ma
  logic              v1;
  logic [DIFF_W-1:0] dx1, dy1;
  logic [63:0]       gm1;
  logic [31:0]       mb1;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= in_valid;
    if (en) begin
      dx1 <= {in_word.b_pos_x[31], in_word.b_pos_x} - {in_word.a_pos_x[31], in_word.a_pos_x};
      dy1 <= {in_word.b_pos_y[31], in_word.b_pos_y} - {in_word.a_pos_y[31], in_word.a_pos_y};
      gm1 <= 64'(in_word.a_mass) * 64'(grav_constant);
      mb1 <= in_word.b_mass;
    end
  end

  // stage 2: magnitudes and signs
  logic              v2;
  logic [DIFF_W-1:0] adx2, ady2;
  gf2d_flags_t       fl2;
  logic [63:0]       gm2;
  logic [31:0]       mb2;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
    if (en) begin
      adx2      <= dx1[DIFF_W-1] ? -dx1 : dx1;
      ady2      <= dy1[DIFF_W-1] ? -dy1 : dy1;
      fl2.neg_x <= dx1[DIFF_W-1];
      fl2.neg_y <= dy1[DIFF_W-1];
      fl2.degen <= (dx1 == '0) && (dy1 == '0);
      gm2       <= gm1;
      mb2       <= mb1;
    end
  end

  // stage 3: squares, mb*|d|
  logic            v3;
  logic [SQ_W-1:0] sx3, sy3;
  logic [63:0]     px3, py3;
  gf2d_flags_t     fl3;
  logic [63:0]     gm3;

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2;
    if (en) begin
      sx3 <= SQ_W'(adx2) * SQ_W'(adx2);
      sy3 <= SQ_W'(ady2) * SQ_W'(ady2);
      px3 <= 64'(mb2) * 64'(adx2);
      py3 <= 64'(mb2) * 64'(ady2);
      fl3 <= fl2;
      gm3 <= gm2;
    end
  end

  // stage 4: squared length, partial products of the numerators
  logic            v4;
  logic [SQ_W-1:0] d2_4;
  logic [63:0]     ppx [4];
  logic [63:0]     ppy [4];
  gf2d_flags_t     fl4;

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (en) v4 <= v3;
    if (en) begin
      d2_4   <= sx3 + sy3;
      ppx[0] <= 64'(gm3[31:0])  * 64'(px3[31:0]);
      ppx[1] <= 64'(gm3[31:0])  * 64'(px3[63:32]);
      ppx[2] <= 64'(gm3[63:32]) * 64'(px3[31:0]);
      ppx[3] <= 64'(gm3[63:32]) * 64'(px3[63:32]);
      ppy[0] <= 64'(gm3[31:0])  * 64'(py3[31:0]);
      ppy[1] <= 64'(gm3[31:0])  * 64'(py3[63:32]);
      ppy[2] <= 64'(gm3[63:32]) * 64'(py3[31:0]);
      ppy[3] <= 64'(gm3[63:32]) * 64'(py3[63:32]);
      fl4    <= fl3;
    end
  end

  // stage 5: clamp squared distance, sum numerators
  logic [SQ_W-1:0]  shifted;
  logic [31:0]      d2s, c_lo, c_hi, c_fin;
  logic [NUM_W-1:0] nx, ny;

  always_comb begin
    shifted = d2_4 >> FRAC_BITS;
    d2s     = (|shifted[SQ_W-1:32]) ? '1 : shifted[31:0];
    c_lo    = (d2s < min_dist_sq) ? min_dist_sq : d2s;
    c_hi    = (c_lo > max_dist_sq) ? max_dist_sq : c_lo;
    c_fin   = (c_hi == '0) ? 32'd1 : c_hi;
    nx = {ppx[3], 64'd0} + {32'd0, ppx[1], 32'd0} + {32'd0, ppx[2], 32'd0}
       + {64'd0, ppx[0]};
    ny = {ppy[3], 64'd0} + {32'd0, ppy[1], 32'd0} + {32'd0, ppy[2], 32'd0}
       + {64'd0, ppy[0]};
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= v4;
    if (en) begin
      d2           <= d2_4;
      side.clamped <= c_fin;
      side.num_x   <= nx;
      side.num_y   <= ny;
      side.flags   <= fl4;
    end
  end

endmodule

>>> hdl/gf2d_isqrt.sv
module gf2d_isqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [gf2d_pkg::SQ_W-1:0]   val,
  input  gf2d_pkg::gf2d_side_t        side_in,
  output logic                        out_valid,
  output logic [gf2d_pkg::ROOT_W-1:0] root,
  output gf2d_pkg::gf2d_side_t        side_out
);
  import gf2d_pkg::*;

  localparam int RM_W = ROOT_W + 3;

  // one root bit per stage, two radicand bits consumed each
  logic              v  [ROOT_W];
  logic [ROOT_W-1:0] rt [ROOT_W];
  logic [RM_W-1:0]   rm [ROOT_W];
  logic [SQ_W-1:0]   vl [ROOT_W];
  gf2d_side_t        sd [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    localparam int I = ROOT_W - 1 - k;
    logic              pv;
    logic [ROOT_W-1:0] prt;
    logic [RM_W-1:0]   prm;
    logic [SQ_W-1:0]   pvl;
    gf2d_side_t        psd;
    logic [RM_W-1:0]   rsh, trial;

    if (k == 0) begin : g_first
      assign pv  = in_valid;
      assign prt = '0;
      assign prm = '0;
      assign pvl = val;
      assign psd = side_in;
    end else begin : g_next
      assign pv  = v[k-1];
      assign prt = rt[k-1];
      assign prm = rm[k-1];
      assign pvl = vl[k-1];
      assign psd = sd[k-1];
    end

    assign rsh   = {prm[RM_W-3:0], pvl[2*I+1], pvl[2*I]};
    assign trial = RM_W'({prt, 2'b01});

    always_ff @(posedge clk) begin
      if (rst) v[k] <= 1'b0;
      else if (en) v[k] <= pv;
      if (en) begin
        vl[k] <= pvl;
        sd[k] <= psd;
        if (rsh >= trial) begin
          rm[k] <= rsh - trial;
          rt[k] <= {prt[ROOT_W-2:0], 1'b1};
        end else begin
          rm[k] <= rsh;
          rt[k] <= {prt[ROOT_W-2:0], 1'b0};
        end
      end
    end
  end

  assign out_valid = v[ROOT_W-1];
  assign root      = rt[ROOT_W-1];
  assign side_out  = sd[ROOT_W-1];

endmodule

>>> hdl/gf2d_divider.sv
module gf2d_divider #(
  parameter int DEN_W = gf2d_pkg::PROD_W + gf2d_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [gf2d_pkg::NUM_W-1:0] num_x,
  input  logic [gf2d_pkg::NUM_W-1:0] num_y,
  input  logic [DEN_W-1:0]           den,
  input  gf2d_pkg::gf2d_flags_t      flags_in,
  output logic                       out_valid,
  output logic [gf2d_pkg::Q_W-1:0]   quo_x,
  output logic [gf2d_pkg::Q_W-1:0]   quo_y,
  output logic                       ovf_x,
  output logic                       ovf_y,
  output gf2d_pkg::gf2d_flags_t      flags_out
);
  import gf2d_pkg::*;

  localparam int NS = Q_W + 1;

  // stage 0 checks quotient >= 2^Q_W, then one quotient bit per stage
  logic             v   [NS];
  logic [NUM_W-1:0] rx  [NS];
  logic [NUM_W-1:0] ry  [NS];
  logic [Q_W-1:0]   qx  [NS];
  logic [Q_W-1:0]   qy  [NS];
  logic             ox  [NS];
  logic             oy  [NS];
  logic [DEN_W-1:0] dn  [NS];
  gf2d_flags_t      fl  [NS];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    if (k == 0) begin : g_first
      logic [NUM_W-1:0] top;
      assign top = NUM_W'(den) << Q_W;
      always_ff @(posedge clk) begin
        if (rst) v[k] <= 1'b0;
        else if (en) v[k] <= in_valid;
        if (en) begin
          rx[k] <= num_x;
          ry[k] <= num_y;
          qx[k] <= '0;
          qy[k] <= '0;
          ox[k] <= num_x >= top;
          oy[k] <= num_y >= top;
          dn[k] <= den;
          fl[k] <= flags_in;
        end
      end
    end else begin : g_next
      localparam int I = Q_W - k;
      logic [NUM_W-1:0] dsh;
      assign dsh = NUM_W'(dn[k-1]) << I;
      always_ff @(posedge clk) begin
        if (rst) v[k] <= 1'b0;
        else if (en) v[k] <= v[k-1];
        if (en) begin
          ox[k] <= ox[k-1];
          oy[k] <= oy[k-1];
          dn[k] <= dn[k-1];
          fl[k] <= fl[k-1];
          if (rx[k-1] >= dsh) begin
            rx[k] <= rx[k-1] - dsh;
            qx[k] <= qx[k-1] | (Q_W'(1) << I);
          end else begin
            rx[k] <= rx[k-1];
            qx[k] <= qx[k-1];
          end
          if (ry[k-1] >= dsh) begin
            ry[k] <= ry[k-1] - dsh;
            qy[k] <= qy[k-1] | (Q_W'(1) << I);
          end else begin
            ry[k] <= ry[k-1];
            qy[k] <= qy[k-1];
          end
        end
      end
    end
  end

  assign out_valid = v[NS-1];
  assign quo_x     = qx[NS-1];
  assign quo_y     = qy[NS-1];
  assign ovf_x     = ox[NS-1];
  assign ovf_y     = oy[NS-1];
  assign flags_out = fl[NS-1];

endmodule

>>> hdl/gravitational_force_2d.sv
// Pipeline from accepted input word to result word: 5 front stages, 33 square-root
// stages, 1 multiply, 33 divide stages, output. Throughput: one word per cycle
// unless the output stalls; the divider does one quotient bit per stage.
// A stalled output word freezes the whole pipeline until it is taken.
// Reset (rst, synchronous, active high) clears all valid bits and loads
// grav_constant = 1.0, min_dist_sq = 1.0, max_dist_sq = all ones.
module gravitational_force_2d #(
  parameter int FRAC_BITS = gf2d_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  gf2d_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output gf2d_pkg::out_word_t out_word,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data
);
  import gf2d_pkg::*;
  `include "gravitational_force_2d_macros.svh"

  localparam int DEN_W = PROD_W + FRAC_BITS;

  // configuration registers
  logic [31:0] grav_constant, min_dist_sq, max_dist_sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      grav_constant <= 32'h0001_0000;
      min_dist_sq   <= 32'h0001_0000;
      max_dist_sq   <= 32'hFFFF_FFFF;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GRAV:    grav_constant <= cfg_data;
        CFG_MIN_DSQ: min_dist_sq   <= cfg_data;
        CFG_MAX_DSQ: max_dist_sq   <= cfg_data;
        default: ;
      endcase
    end
  end

  // global advance: everything moves unless the output word is held
  logic en;
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  // front end
  logic            fr_valid;
  logic [SQ_W-1:0] fr_d2;
  gf2d_side_t      fr_side;

  gf2d_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk, .rst, .en,
    .in_valid, .in_word,
    .grav_constant, .min_dist_sq, .max_dist_sq,
    .out_valid(fr_valid), .d2(fr_d2), .side(fr_side)
  );

  // square root of the exact squared length
  logic              sq_valid;
  logic [ROOT_W-1:0] sq_root;
  gf2d_side_t        sq_side;

  gf2d_isqrt u_isqrt (
    .clk, .rst, .en,
    .in_valid(fr_valid), .val(fr_d2), .side_in(fr_side),
    .out_valid(sq_valid), .root(sq_root), .side_out(sq_side)
  );

  // divisor = clamped * len, scaled by 2^F on the way into the divider
  logic              m_valid;
  logic [PROD_W-1:0] m_prod;
  logic [NUM_W-1:0]  m_num_x, m_num_y;
  gf2d_flags_t       m_flags;

  always_ff @(posedge clk) begin
    if (rst) m_valid <= 1'b0;
    else if (en) m_valid <= sq_valid;
    if (en) begin
      m_prod  <= PROD_W'(sq_side.clamped) * PROD_W'(sq_root);
      m_num_x <= sq_side.num_x;
      m_num_y <= sq_side.num_y;
      m_flags <= sq_side.flags;
    end
  end

  logic [DEN_W-1:0] den;
  assign den = {m_prod, {FRAC_BITS{1'b0}}};

  logic           div_valid, ovf_x, ovf_y;
  logic [Q_W-1:0] quo_x, quo_y;
  gf2d_flags_t    div_flags;

  gf2d_divider #(.DEN_W(DEN_W)) u_divider (
    .clk, .rst, .en,
    .in_valid(m_valid), .num_x(m_num_x), .num_y(m_num_y), .den,
    .flags_in(m_flags),
    .out_valid(div_valid), .quo_x, .quo_y, .ovf_x, .ovf_y,
    .flags_out(div_flags)
  );

  // saturate a magnitude against the signed range and apply the sign
  function automatic logic [32:0] sat_lane(logic [Q_W-1:0] q, logic ovf, logic neg);
    logic [31:0] lim, mag;
    logic        sat;
    lim = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    sat = ovf || (q > lim);
    mag = sat ? lim : q;
    return {sat, neg ? -mag : mag};
  endfunction

  logic [32:0] lx, ly;
  out_word_t   res;

  always_comb begin
    lx = sat_lane(quo_x, ovf_x, div_flags.neg_x);
    ly = sat_lane(quo_y, ovf_y, div_flags.neg_y);
    if (div_flags.degen) begin
      res.force_x    = '0;
      res.force_y    = '0;
      res.saturated  = 1'b0;
      res.degenerate = 1'b1;
    end else begin
      res.force_x    = lx[31:0];
      res.force_y    = ly[31:0];
      res.saturated  = lx[32] | ly[32];
      res.degenerate = 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= div_valid;
    if (en) out_word <= res;
  end

  `GF2D_ASSERT_IMPL(a_degen_zero, out_valid && out_word.degenerate,
    out_word.force_x == '0 && out_word.force_y == '0 && !out_word.saturated,
    "degenerate word carries a nonzero force")
  `GF2D_ASSERT_IMPL(a_sat_clip, out_valid && out_word.saturated,
    out_word.force_x == 32'h7FFF_FFFF || out_word.force_x == 32'h8000_0000 ||
    out_word.force_y == 32'h7FFF_FFFF || out_word.force_y == 32'h8000_0000,
    "saturated word has no clipped component")
  `GF2D_ASSERT_IMPL(a_stall_cause, in_stall, out_valid && out_stall,
    "input stalled without a held output word")
  `GF2D_ASSERT_NEXT(a_freeze, in_stall,
    $stable(div_valid) && $stable(sq_valid) && $stable(fr_valid),
    "pipeline moved while frozen")

endmodule

>>> dv/gravitational_force_2d_tb.sv
`timescale 1ns / 100ps

module gravitational_force_2d_tb;
  import gf2d_pkg::*;

  localparam int FB = 16;
  localparam int LATENCY = 73;

  // Force predictor: fixed-point Newtonian pull of b on a, clamped distance
  class force_scoreboard;
    logic [31:0] grav;
    logic [31:0] min_dsq;
    logic [31:0] max_dsq;
    out_word_t   pending[$];
    int          n_fail;
    int          n_checked;
    int          n_sat;
    int          n_degen;

    function new();
      grav = 32'h0001_0000;
      min_dsq = 32'h0001_0000;
      max_dsq = 32'hFFFF_FFFF;
      n_fail = 0;
      n_checked = 0;
      n_sat = 0;
      n_degen = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] val);
      if (idx == CFG_GRAV) grav = val;
      else if (idx == CFG_MIN_DSQ) min_dsq = val;
      else if (idx == CFG_MAX_DSQ) max_dsq = val;
    endfunction

    // floor sqrt of a value below 2^67
    function logic [33:0] sqrt_floor(logic [66:0] v);
      logic [33:0] root;
      logic [69:0] rem;
      logic [69:0] trial;
      root = '0;
      rem = '0;
      for (int i = 33; i >= 0; i--) begin
        rem = (rem << 2) | ((2 * i + 1 <= 66) ? v[2 * i + 1] << 1 : 0) | v[2 * i];
        trial = {root, 2'b01};
        if (rem >= trial) begin
          rem = rem - trial;
          root = {root[32:0], 1'b1};
        end else begin
          root = {root[32:0], 1'b0};
        end
      end
      return root;
    endfunction

    function logic [31:0] axis_force(logic signed [32:0] d, logic [63:0] gm,
                                     logic [31:0] mb, logic [47:0] div1,
                                     logic [33:0] len, inout logic sat);
      logic [32:0]  ad;
      logic [127:0] num;
      logic [127:0] q;
      logic [31:0]  lim;
      logic         neg;
      neg = d < 0;
      ad = neg ? -d : d;
      // mb*|d| always fits in 64 bits
      num = 128'(gm) * 128'(64'(64'(mb) * 64'(ad)));
      q = (num / 128'(div1)) / 128'(len);
      lim = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
      if (q > 128'(lim)) begin
        sat = 1'b1;
        q = 128'(lim);
      end
      return neg ? -q[31:0] : q[31:0];
    endfunction

    function out_word_t predict(in_word_t w);
      out_word_t r;
      logic signed [32:0] dx;
      logic signed [32:0] dy;
      logic [32:0] adx;
      logic [32:0] ady;
      logic [66:0] d2;
      logic [50:0] d2s;
      logic [31:0] clamped;
      logic [33:0] len;
      logic sat;
      dx = 33'(w.b_pos_x) - 33'(w.a_pos_x);
      dy = 33'(w.b_pos_y) - 33'(w.a_pos_y);
      r = '0;
      if (dx == 0 && dy == 0) begin
        r.degenerate = 1'b1;
        return r;
      end
      adx = dx < 0 ? -dx : dx;
      ady = dy < 0 ? -dy : dy;
      d2 = 67'(adx) * 67'(adx) + 67'(ady) * 67'(ady);
      d2s = 51'(d2 >> FB);
      clamped = (d2s > 51'hFFFF_FFFF) ? 32'hFFFF_FFFF : d2s[31:0];
      if (clamped < min_dsq) clamped = min_dsq;
      if (clamped > max_dsq) clamped = max_dsq;
      if (clamped == 0) clamped = 32'd1;
      len = sqrt_floor(d2);
      sat = 1'b0;
      r.force_x = axis_force(dx, 64'(grav) * 64'(w.a_mass), w.b_mass,
                             48'(clamped) << FB, len, sat);
      r.force_y = axis_force(dy, 64'(grav) * 64'(w.a_mass), w.b_mass,
                             48'(clamped) << FB, len, sat);
      r.saturated = sat;
      return r;
    endfunction

    function void note_input(in_word_t w);
      pending.push_back(predict(w));
    endfunction

    function void check_result(out_word_t got);
      out_word_t exp_w;
      if (pending.size() == 0) begin
        $error("result word with nothing expected: %h", got);
        n_fail++;
        return;
      end
      exp_w = pending.pop_front();
      n_checked++;
      if (exp_w.saturated) n_sat++;
      if (exp_w.degenerate) n_degen++;
      if (got.force_x !== exp_w.force_x) begin
        $error("force_x exp %h got %h", exp_w.force_x, got.force_x);
        n_fail++;
      end
      if (got.force_y !== exp_w.force_y) begin
        $error("force_y exp %h got %h", exp_w.force_y, got.force_y);
        n_fail++;
      end
      if (got.saturated !== exp_w.saturated) begin
        $error("saturated exp %b got %b", exp_w.saturated, got.saturated);
        n_fail++;
      end
      if (got.degenerate !== exp_w.degenerate) begin
        $error("degenerate exp %b got %b", exp_w.degenerate, got.degenerate);
        n_fail++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  in_word_t    in_word;
  logic        out_valid;
  logic        out_stall;
  out_word_t   out_word;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  force_scoreboard sb;
  bit src_idle_on;
  bit sink_idle_on;
  bit sink_hold;
  int n_sent;

  gravitational_force_2d i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog
  initial begin
    #3_000_000;
    $display("timeout");
    $display("*** FAILED ***");
    $finish;
  end

  // Monitor: input acceptance and result checking
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.note_input(in_word);
      if (out_valid && !out_stall) sb.check_result(out_word);
    end
  end

  // Receiver: random stall bursts, or a long hold when asked
  initial begin
    int n;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (sink_hold) begin
        out_stall <= 1'b1;
      end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 18);
        out_stall <= 1'b1;
        repeat (n - 1) @(posedge clk);
        @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      4: return $urandom_range(0, 32'h0004_0000);
      default: return $urandom;
    endcase
  endfunction

  // Mostly moderate values so forces land in range; some wild ones
  function automatic in_word_t rand_pair();
    in_word_t w;
    int k;
    k = $urandom_range(0, 9);
    if (k < 6) begin
      w.a_pos_x = $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
      w.a_pos_y = $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
      w.b_pos_x = $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
      w.b_pos_y = $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
      w.a_mass = $urandom_range(0, 32'h0040_0000);
      w.b_mass = $urandom_range(0, 32'h0040_0000);
    end else begin
      w.a_pos_x = rand_word();
      w.a_pos_y = rand_word();
      w.b_pos_x = rand_word();
      w.b_pos_y = rand_word();
      w.a_mass = rand_word();
      w.b_mass = rand_word();
    end
    if (k == 9) begin
      w.b_pos_x = w.a_pos_x;
      w.b_pos_y = w.a_pos_y;
    end
    return w;
  endfunction

  task automatic send_word(in_word_t w);
    int n;
    if (src_idle_on && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 18);
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_sent++;
  endtask

  task automatic end_burst();
    in_valid <= 1'b0;
  endtask

  task automatic drain();
    end_burst();
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  // one write, then cfg_we low again before returning, so back-to-back writes never collide
  task automatic write_cfg(logic [1:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    sb.write_reg(idx, val);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_pos(logic [31:0] ax, logic [31:0] ay, logic [31:0] bx,
                          logic [31:0] by, logic [31:0] am, logic [31:0] bm);
    in_word_t w;
    w.a_pos_x = ax;
    w.a_pos_y = ay;
    w.b_pos_x = bx;
    w.b_pos_y = by;
    w.a_mass = am;
    w.b_mass = bm;
    send_word(w);
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    in_valid = 1'b0;
    in_word = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_GRAV;
    cfg_data = '0;
    src_idle_on = 1'b0;
    sink_idle_on = 1'b0;
    sink_hold = 1'b0;
    n_sent = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed words at reset settings
    send_pos(0, 0, 32'h0001_0000, 0, 32'h0001_0000, 32'h0001_0000);
    send_pos(0, 0, 0, 32'hFFFF_0000, 32'h0002_0000, 32'h0003_0000);
    send_pos(32'h1234_5678, 32'h9ABC_DEF0, 32'h1234_5678, 32'h9ABC_DEF0,
             32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_pos(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
             32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_pos(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
             32'h0000_0001, 32'h0000_0001);
    send_pos(0, 0, 1, 0, 32'h0100_0000, 32'h0100_0000);
    send_pos(0, 0, 1, 1, 0, 32'h0001_0000);
    send_pos(32'h0003_0000, 32'h0004_0000, 0, 0, 32'h000A_0000, 32'h0005_0000);
    send_pos(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000,
             32'h8000_0000, 32'h8000_0000);
    drain();

    // Zero lower bound: tiny distances clamp to zero, which is forced to one
    write_cfg(CFG_MIN_DSQ, 32'h0);
    write_cfg(CFG_GRAV, 32'hFFFF_FFFF);
    send_pos(0, 0, 1, 0, 32'h0001_0000, 32'h0001_0000);
    send_pos(0, 0, 0, 1, 1, 1);
    send_pos(5, 5, 4, 4, 32'h0000_0100, 32'h0000_0100);
    drain();

    // Crossed bounds: clamp lands on the upper bound
    write_cfg(CFG_MIN_DSQ, 32'hFFFF_FFFF);
    write_cfg(CFG_MAX_DSQ, 32'h0004_0000);
    write_cfg(CFG_GRAV, 32'h0);
    send_pos(0, 0, 32'h0010_0000, 0, 32'h0001_0000, 32'h0001_0000);
    drain();
    write_cfg(CFG_GRAV, 32'h0000_4000);
    send_pos(0, 0, 32'h0010_0000, 32'h0002_0000, 32'h0001_0000, 32'h0001_0000);
    drain();
    write_cfg(CFG_MAX_DSQ, 32'h0);
    send_pos(0, 0, 32'h0000_0100, 0, 32'h0001_0000, 32'h0001_0000);
    drain();

    // Random phases across several settings
    src_idle_on = 1'b1;
    sink_idle_on = 1'b1;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          write_cfg(CFG_GRAV, 32'h0001_0000);
          write_cfg(CFG_MIN_DSQ, 32'h0001_0000);
          write_cfg(CFG_MAX_DSQ, 32'hFFFF_FFFF);
        end
        1: begin
          write_cfg(CFG_GRAV, $urandom);
          write_cfg(CFG_MIN_DSQ, $urandom_range(0, 32'h0100_0000));
          write_cfg(CFG_MAX_DSQ, $urandom);
        end
        2: begin
          write_cfg(CFG_GRAV, $urandom_range(0, 32'h0010_0000));
          write_cfg(CFG_MIN_DSQ, 32'h0);
          write_cfg(CFG_MAX_DSQ, 32'h4000_0000);
        end
        default: begin
          write_cfg(CFG_GRAV, 32'h0000_8000);
          write_cfg(CFG_MIN_DSQ, 32'h0000_1000);
          write_cfg(CFG_MAX_DSQ, 32'hFFFF_FFFF);
        end
      endcase
      if (ph == 1) begin
        // long receiver hold while sender keeps offering words
        fork
          begin
            sink_hold = 1'b1;
            repeat (200) @(posedge clk);
            sink_hold = 1'b0;
          end
          begin
            for (int i = 0; i < 110; i++) send_word(rand_pair());
          end
        join
      end else begin
        for (int i = 0; i < 110; i++) send_word(rand_pair());
      end
      if (ph == 3) begin
        src_idle_on = 1'b0;
        sink_idle_on = 1'b0;
        for (int i = 0; i < 40; i++) send_word(rand_pair());
      end
      drain();
    end

    $display("Sent %0d words, checked %0d results (%0d saturated, %0d degenerate).",
             n_sent, sb.n_checked, sb.n_sat, sb.n_degen);
    $display("Covered reset, zero, crossed and random distance bounds.");
    if (sb.n_fail == 0 && sb.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+hdl
hdl/gf2d_pkg.sv
hdl/gf2d_front.sv
hdl/gf2d_isqrt.sv
hdl/gf2d_divider.sv
hdl/gravitational_force_2d.sv
dv/gravitational_force_2d_tb.sv
